/* rtl/core/flash_gc_victim_select_macros.svh */
// Assertion macros shared by the victim select checker.
`ifndef FLASH_GC_VICTIM_SELECT_MACROS_SVH
`define FLASH_GC_VICTIM_SELECT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define FGVS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define FGVS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/fgvs_pkg.sv */
// Types and constants of the flash GC victim select block.
`default_nettype none

package fgvs_pkg;

   // Clamp limits applied to the configuration registers
   localparam int unsigned MAX_PAGES_PER_ROW = 256;
   localparam int unsigned MAX_ROWS          = 255;

   // Page status codes
   localparam logic [7:0] STATUS_DELETED = 8'h00;
   localparam logic [7:0] STATUS_FREE    = 8'hff;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGES_PER_ROW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_META_ROW_COUNT = 2'd2;

   // Configuration reset values
   localparam logic [8:0] PAGES_PER_ROW_RESET  = 9'd16;
   localparam logic [7:0] ROW_COUNT_RESET      = 8'd63;
   localparam logic [6:0] META_ROW_COUNT_RESET = 7'd2;

   typedef struct packed {
      logic       forced;
      logic       data_space;
      logic [7:0] row;
      logic [7:0] slot;
      logic [7:0] status_byte;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  victim_row;
      logic [7:0]  victim_deleted;
      logic        do_collect;
      logic        out_of_space;
      logic [15:0] free_pages;
      logic [15:0] deleted_pages;
      logic [15:0] full_pages;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_payload_type;

endpackage

`default_nettype wire

/* rtl/core/fgvs_channels_if.sv */
// Valid/ready channel interfaces of the flash GC victim select block.
`default_nettype none

interface fgvs_req_if;
   logic                     valid;
   logic                     ready;
   fgvs_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fgvs_rsp_if;
   logic                     valid;
   logic                     ready;
   fgvs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fgvs_csr_if;
   logic                     valid;
   logic                     ready;
   fgvs_pkg::csr_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/flash_gc_victim_select.sv */
// Flash GC greedy victim select: page status counting and victim row tracking.
`default_nettype none

// Status bytes stream in one transaction per cycle, row by row, when no stall
// holds them. Each byte is latched in an input register, then classified and
// folded into the counters, so an item enters every cycle unless stalled; its
// result (only on the last byte of a pass) is written to the result register.
// The only stall comes from the result register: a last byte waits in the
// input register while an earlier result is still untaken. Configuration
// writes are taken every cycle and must only happen while the block is idle.
module flash_gc_victim_select (
   input  wire logic        clock,
   input  wire logic        reset,
   fgvs_req_if.sink         req_chan,
   fgvs_rsp_if.source       rsp_chan,
   fgvs_csr_if.sink         csr_chan
);
   import fgvs_pkg::*;

   // Configuration registers
   logic [8:0] pages_per_row_ff;
   logic [7:0] row_count_ff;
   logic [6:0] meta_row_count_ff;

   // Input stage
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_payload_ff;
   logic            s1_fire;

   // Pass state
   logic [15:0] free_total_ff, free_total_in;
   logic [15:0] deleted_total_ff, deleted_total_in;
   logic [15:0] full_total_ff, full_total_in;
   logic [7:0]  row_deleted_ff, row_deleted_in;
   logic [7:0]  best_deleted_ff, best_deleted_in;
   logic [7:0]  best_row_ff, best_row_in;
   logic [7:0]  cur_row_ff;
   logic        in_pass_ff;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Datapath terms
   logic [8:0]  ppr;
   logic [7:0]  rows;
   logic [7:0]  range_lo;
   logic [7:0]  range_hi;
   logic        pass_start;
   logic        counted;
   logic        is_deleted;
   logic        is_free;
   logic [7:0]  row_base;
   logic [7:0]  best_base;
   logic [15:0] free_base, deleted_base, full_base;
   logic [10:0] best_x5;

   // Configuration writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_per_row_ff  <= PAGES_PER_ROW_RESET;
         row_count_ff      <= ROW_COUNT_RESET;
         meta_row_count_ff <= META_ROW_COUNT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.payload.index)
            CSR_PAGES_PER_ROW:  pages_per_row_ff  <= csr_chan.payload.data;
            CSR_ROW_COUNT:      row_count_ff      <= csr_chan.payload.data[7:0];
            CSR_META_ROW_COUNT: meta_row_count_ff <= csr_chan.payload.data[6:0];
            default: ;
         endcase
      end
   end

   // Advance the input stage unless a last byte meets an occupied result register that is not being taken
   assign s1_fire        = s1_valid_ff &&
                           (!s1_payload_ff.last || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign s1_valid_in    = (req_chan.valid && req_chan.ready) ? 1'b1
                         : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_payload_ff <= req_chan.payload;
      end
   end

   // Clamp the configuration and pick the scanned row range
   always_comb begin
      ppr  = (pages_per_row_ff > 9'(MAX_PAGES_PER_ROW)) ? 9'(MAX_PAGES_PER_ROW)
                                                        : pages_per_row_ff;
      rows = (row_count_ff > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : row_count_ff;
      range_lo = 8'd0;
      range_hi = rows;
      if (s1_payload_ff.forced) begin
         if (s1_payload_ff.data_space) begin
            range_lo = {1'b0, meta_row_count_ff};
         end else begin
            range_hi = {1'b0, meta_row_count_ff};
         end
      end
   end

   // Classify the byte
   assign counted = (s1_payload_ff.row >= range_lo) && (s1_payload_ff.row < range_hi) &&
                    (s1_payload_ff.slot != 8'd0) && (ppr >= 9'd2) &&
                    ({1'b0, s1_payload_ff.slot} < (ppr - 9'd1));
   assign is_deleted = (s1_payload_ff.status_byte == STATUS_DELETED);
   assign is_free    = (s1_payload_ff.status_byte == STATUS_FREE);

   // Restart the counts at the start of a pass (the totals only when not forced), and the row count on a row change
   assign pass_start   = !in_pass_ff;
   assign row_base     = (pass_start || s1_payload_ff.row != cur_row_ff) ? 8'd0
                                                                          : row_deleted_ff;
   assign best_base    = pass_start ? 8'd0 : best_deleted_ff;
   assign free_base    = (pass_start && !s1_payload_ff.forced) ? 16'd0 : free_total_ff;
   assign deleted_base = (pass_start && !s1_payload_ff.forced) ? 16'd0 : deleted_total_ff;
   assign full_base    = (pass_start && !s1_payload_ff.forced) ? 16'd0 : full_total_ff;

   // Update the row count, the victim and, outside forced passes, the totals
   always_comb begin
      row_deleted_in   = row_base;
      best_deleted_in  = best_base;
      best_row_in      = pass_start ? 8'd0 : best_row_ff;
      free_total_in    = free_base;
      deleted_total_in = deleted_base;
      full_total_in    = full_base;
      if (counted && is_deleted) begin
         if (row_base != 8'hff) begin
            row_deleted_in = row_base + 8'd1;
         end
         if (row_deleted_in > best_base) begin
            best_deleted_in = row_deleted_in;
            best_row_in     = s1_payload_ff.row;
         end
      end
      if (counted && !s1_payload_ff.forced) begin
         if (is_deleted) begin
            if (deleted_base != 16'hffff) deleted_total_in = deleted_base + 16'd1;
         end else if (is_free) begin
            if (free_base != 16'hffff) free_total_in = free_base + 16'd1;
         end else begin
            if (full_base != 16'hffff) full_total_in = full_base + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_total_ff    <= 16'd0;
         deleted_total_ff <= 16'd0;
         full_total_ff    <= 16'd0;
         row_deleted_ff   <= 8'd0;
         best_deleted_ff  <= 8'd0;
         best_row_ff      <= 8'd0;
         cur_row_ff       <= 8'd0;
         in_pass_ff       <= 1'b0;
      end else if (s1_fire) begin
         free_total_ff    <= free_total_in;
         deleted_total_ff <= deleted_total_in;
         full_total_ff    <= full_total_in;
         row_deleted_ff   <= row_deleted_in;
         best_deleted_ff  <= best_deleted_in;
         best_row_ff      <= best_row_in;
         cur_row_ff       <= s1_payload_ff.row;
         in_pass_ff       <= !s1_payload_ff.last;
      end
   end

   // Build the result on the last byte of a pass
   assign best_x5 = {1'b0, best_deleted_in, 2'b00} + {3'b000, best_deleted_in};

   always_comb begin
      rsp_payload_in.victim_row     = best_row_in;
      rsp_payload_in.victim_deleted = best_deleted_in;
      rsp_payload_in.do_collect     = s1_payload_ff.forced ||
                                      ({1'b0, best_deleted_in} > (ppr >> 1)) ||
                                      ({5'd0, best_x5} > free_total_in);
      rsp_payload_in.out_of_space   = s1_payload_ff.forced && (best_deleted_in == 8'd0);
      rsp_payload_in.free_pages     = free_total_in;
      rsp_payload_in.deleted_pages  = deleted_total_in;
      rsp_payload_in.full_pages     = full_total_in;
   end

   // Hold the result until the sink takes it
   assign rsp_valid_in = (s1_fire && s1_payload_ff.last) ? 1'b1
                       : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_payload_ff.last) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* rtl/core/fgvs_checker.sv */
// Port-level assertions for the flash GC victim select block and their bind.
`default_nettype none
`include "flash_gc_victim_select_macros.svh"

module fgvs_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire fgvs_pkg::rsp_payload_type rsp_payload
);
   import fgvs_pkg::*;

   // A stalled result transaction keeps its contents
   `FGVS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // Running out of space always asks for a collection
   `FGVS_ASSERT(a_oos_collect, clock, reset, rsp_valid && rsp_payload.out_of_space |-> rsp_payload.do_collect, "out of space without collect")

   // With no deleted page the victim row stays at zero
   `FGVS_ASSERT(a_empty_victim, clock, reset, rsp_valid && rsp_payload.victim_deleted == 8'd0 |-> rsp_payload.victim_row == 8'd0, "victim row set without deleted pages")

   // No result is offered right after reset
   `FGVS_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind flash_gc_victim_select fgvs_checker u_fgvs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire
